### src/ctab_pkg.sv
package ctab_pkg;

    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int SLOT_IN_W = 8;
    localparam int COUNT_W  = $clog2(SLOTS + 1);
    localparam int TYPE_W   = 3;
    localparam int RIGHTS_W = 8;
    localparam int WORD_W   = 64;
    localparam int GEN_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int BIT_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [TYPE_W-1:0] TYPE_NONE    = '0;
    localparam logic [GEN_W-1:0]  GEN_RESET    = GEN_W'(1);
    localparam logic [BIT_W-1:0]  GRANT_RESET  = BIT_W'(2);
    localparam logic [BIT_W-1:0]  REVOKE_RESET = BIT_W'(3);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRANT_BIT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVOKE_BIT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 3'd0,
        FN_LOOKUP = 3'd1,
        FN_DELETE = 3'd2,
        FN_COPY   = 3'd3,
        FN_MINT   = 3'd4,
        FN_REVOKE = 3'd5
    } func_t;

    typedef struct packed {
        logic [TYPE_W-1:0]   cap_type;
        logic [RIGHTS_W-1:0] rights;
        logic [WORD_W-1:0]   object_ref;
        logic [WORD_W-1:0]   badge;
        logic [GEN_W-1:0]    generation;
    } entry_t;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SLOT_IN_W-1:0] slot;
        logic [SLOT_IN_W-1:0] dest_slot;
        logic                 dst_auto;
        logic [TYPE_W-1:0]    cap_type;
        logic [RIGHTS_W-1:0]  rights;
        logic [WORD_W-1:0]    object_ref;
        logic [WORD_W-1:0]    badge;
    } req_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } wr_t;

    typedef struct packed {
        logic [SLOTS-1:0]   used_map;
        logic [COUNT_W-1:0] occupied;
    } stat_t;

    typedef struct packed {
        logic                ok;
        logic [SLOT_W-1:0]   result_slot;
        logic [TYPE_W-1:0]   cap_type;
        logic [RIGHTS_W-1:0] rights;
        logic [WORD_W-1:0]   object_ref;
        logic [WORD_W-1:0]   badge;
        logic [GEN_W-1:0]    generation;
        logic [COUNT_W-1:0]  used_count;
    } res_t;

endpackage

### src/ctab_store.sv
module ctab_store (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [ctab_pkg::SLOT_W-1:0] rd_addr,
    output ctab_pkg::entry_t            rd_data,
    input  ctab_pkg::wr_t               wr
);
    import ctab_pkg::*;

    entry_t mem [SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // same-edge write is forwarded so a following request sees it
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr.en && (wr.addr == rd_addr))
            begin
                rd_data_reg <= wr.data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/ctab_ctrl.sv
module ctab_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  ctab_pkg::req_t             req,
    input  ctab_pkg::entry_t           src,
    input  logic [ctab_pkg::BIT_W-1:0] grant_bit,
    input  logic [ctab_pkg::BIT_W-1:0] revoke_bit,
    output ctab_pkg::wr_t              wr,
    output ctab_pkg::stat_t            stat,
    output logic                       done,
    output ctab_pkg::res_t             res
);
    import ctab_pkg::*;

    logic [SLOTS-1:0]   used_reg;
    logic [SLOTS-1:0]   used_next;
    logic [COUNT_W-1:0] occupied_reg;
    logic [COUNT_W-1:0] occupied_next;
    logic [GEN_W-1:0]   gen_reg;
    logic [GEN_W-1:0]   gen_next;
    logic               done_reg;
    res_t               res_reg;
    res_t               res_next;

    logic [SLOT_W-1:0]  free_idx;
    logic               any_free;
    logic [SLOT_W-1:0]  src_idx;
    logic               src_live;
    logic [SLOT_W-1:0]  dst_idx;
    logic               dst_ok;
    logic               set_bit;
    logic               clr_bit;

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign any_free = ~&used_reg;
    assign src_idx  = req.slot[SLOT_W-1:0];
    assign src_live = (req.slot[SLOT_IN_W-1:SLOT_W] == '0) && used_reg[src_idx];

    always_comb
    begin
        if (req.dst_auto)
        begin
            dst_idx = free_idx;
            dst_ok  = any_free;
        end
        else
        begin
            dst_idx = req.dest_slot[SLOT_W-1:0];
            dst_ok  = (req.dest_slot[SLOT_IN_W-1:SLOT_W] == '0) && !used_reg[dst_idx];
        end
    end

    always_comb
    begin
        used_next = used_reg;
        gen_next  = gen_reg;
        set_bit   = 1'b0;
        clr_bit   = 1'b0;
        wr        = '0;
        res_next  = '0;
        if (req_valid)
        begin
            unique case (func_t'(req.func))
                FN_INSERT:
                begin
                    if ((req.cap_type != TYPE_NONE) && any_free)
                    begin
                        wr.en                 = 1'b1;
                        wr.addr               = free_idx;
                        wr.data.cap_type      = req.cap_type;
                        wr.data.rights        = req.rights;
                        wr.data.object_ref    = req.object_ref;
                        wr.data.badge         = req.badge;
                        wr.data.generation    = gen_reg;
                        set_bit               = 1'b1;
                        used_next[free_idx]   = 1'b1;
                        res_next.ok           = 1'b1;
                        res_next.result_slot  = free_idx;
                    end
                end
                FN_LOOKUP:
                begin
                    if (src_live)
                    begin
                        res_next.ok         = 1'b1;
                        res_next.cap_type   = src.cap_type;
                        res_next.rights     = src.rights;
                        res_next.object_ref = src.object_ref;
                        res_next.badge      = src.badge;
                        res_next.generation = src.generation;
                    end
                end
                FN_DELETE:
                begin
                    if (src_live)
                    begin
                        clr_bit            = 1'b1;
                        used_next[src_idx] = 1'b0;
                        res_next.ok        = 1'b1;
                    end
                end
                FN_COPY, FN_MINT:
                begin
                    if (src_live && src.rights[grant_bit] && dst_ok)
                    begin
                        wr.en              = 1'b1;
                        wr.addr            = dst_idx;
                        wr.data            = src;
                        wr.data.generation = gen_reg;
                        if (func_t'(req.func) == FN_MINT)
                        begin
                            wr.data.rights = src.rights & req.rights;
                            wr.data.badge  = req.badge;
                        end
                        set_bit              = 1'b1;
                        used_next[dst_idx]   = 1'b1;
                        res_next.ok          = 1'b1;
                        res_next.result_slot = dst_idx;
                    end
                end
                FN_REVOKE:
                begin
                    if (src_live && src.rights[revoke_bit])
                    begin
                        gen_next    = gen_reg + GEN_W'(1);
                        res_next.ok = 1'b1;
                    end
                end
                default:
                begin
                    res_next.ok = 1'b0;
                end
            endcase
        end
        occupied_next       = occupied_reg + COUNT_W'(set_bit) - COUNT_W'(clr_bit);
        res_next.used_count = occupied_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            occupied_reg <= '0;
            gen_reg      <= GEN_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            used_reg     <= used_next;
            occupied_reg <= occupied_next;
            gen_reg      <= gen_next;
            done_reg     <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            res_reg <= res_next;
        end
    end

    assign stat.used_map = used_reg;
    assign stat.occupied = occupied_reg;
    assign done          = done_reg;
    assign res           = res_reg;

endmodule

### src/capability_table_engine.sv
// capability slot table: insert, lookup, delete, copy, mint and revoke requests
// done and the result are registered: a request passes req_valid_reg, then done_reg and res_reg
// throughput: one request per cycle, busy stays low; set by the single slot memory
// read port, whose same-edge write forwarding hides the back-to-back hazard
// reset (rst_n, async, active low): table empty, generation one, rights bits 2 and 3
// results are presented for one cycle only; the receiver cannot stall them
module capability_table_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            start,
    output logic                            busy,
    input  logic [ctab_pkg::FUNC_W-1:0]     func,
    input  logic [ctab_pkg::SLOT_IN_W-1:0]  slot,
    input  logic [ctab_pkg::SLOT_IN_W-1:0]  dest_slot,
    input  logic                            dst_auto,
    input  logic [ctab_pkg::TYPE_W-1:0]     cap_type,
    input  logic [ctab_pkg::RIGHTS_W-1:0]   rights,
    input  logic [ctab_pkg::WORD_W-1:0]     object_ref,
    input  logic [ctab_pkg::WORD_W-1:0]     badge,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ctab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ctab_pkg::CFG_DATA_W-1:0] cfg_data,
    // result channel
    output logic                            done,
    output logic                            ok,
    output logic [ctab_pkg::SLOT_W-1:0]     result_slot,
    output logic [ctab_pkg::TYPE_W-1:0]     out_type,
    output logic [ctab_pkg::RIGHTS_W-1:0]   out_rights,
    output logic [ctab_pkg::WORD_W-1:0]     out_object,
    output logic [ctab_pkg::WORD_W-1:0]     out_badge,
    output logic [ctab_pkg::GEN_W-1:0]      out_generation,
    output logic [ctab_pkg::COUNT_W-1:0]    used_count
);
    import ctab_pkg::*;

    // rights bit positions
    logic [BIT_W-1:0] grant_bit_reg;
    logic [BIT_W-1:0] revoke_bit_reg;

    // request register, captured at accept, feeds the decision logic in the following cycle
    req_t   req_reg;
    logic   req_valid_reg;
    logic   accept;

    entry_t src_entry;
    wr_t    wr;
    stat_t  stat;
    res_t   res;

    // every request is taken: the table never back-pressures
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grant_bit_reg  <= GRANT_RESET;
            revoke_bit_reg <= REVOKE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRANT_BIT:  grant_bit_reg  <= cfg_data[BIT_W-1:0];
                CFG_REVOKE_BIT: revoke_bit_reg <= cfg_data[BIT_W-1:0];
                default:        grant_bit_reg  <= grant_bit_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= accept;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.func       <= func;
            req_reg.slot       <= slot;
            req_reg.dest_slot  <= dest_slot;
            req_reg.dst_auto   <= dst_auto;
            req_reg.cap_type   <= cap_type;
            req_reg.rights     <= rights;
            req_reg.object_ref <= object_ref;
            req_reg.badge      <= badge;
        end
    end

    // source entry is read at the accepting edge, straight from the slot port;
    // only its low bits address the memory, range is checked in the control
    ctab_store u_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (slot[SLOT_W-1:0]),
        .rd_data (src_entry),
        .wr      (wr)
    );

    // used map, count, space generation, decision and result register
    ctab_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid_reg),
        .req        (req_reg),
        .src        (src_entry),
        .grant_bit  (grant_bit_reg),
        .revoke_bit (revoke_bit_reg),
        .wr         (wr),
        .stat       (stat),
        .done       (done),
        .res        (res)
    );

    assign ok             = res.ok;
    assign result_slot    = res.result_slot;
    assign out_type       = res.cap_type;
    assign out_rights     = res.rights;
    assign out_object     = res.object_ref;
    assign out_badge      = res.badge;
    assign out_generation = res.generation;
    assign used_count     = res.used_count;

    // count must track the used map exactly
    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        stat.occupied == COUNT_W'($countones(stat.used_map)))
        else $error("occupied count out of step with used map");

    // a write never lands on an occupied slot
    a_write_to_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> !stat.used_map[wr.addr])
        else $error("slot write targets an occupied slot");

    // every result strobe comes from an accepted request, carried through req_valid_reg and done_reg
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without matching request");

    // a failed request reports no slot and no entry
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (result_slot == '0 && out_type == TYPE_NONE))
        else $error("failed request carries payload");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ctab_pkg::*;

    // function codes outside the defined set
    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    localparam int IDLE_LIMIT  = 2000;
    localparam int PRINT_LIMIT = 100;
    localparam int PHASE_ITEMS = 190;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 start = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    func = '0;
    logic [SLOT_IN_W-1:0] slot = '0;
    logic [SLOT_IN_W-1:0] dest_slot = '0;
    logic                 dst_auto = 1'b0;
    logic [TYPE_W-1:0]    cap_type = '0;
    logic [RIGHTS_W-1:0]  rights = '0;
    logic [WORD_W-1:0]    object_ref = '0;
    logic [WORD_W-1:0]    badge = '0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                done;
    logic                ok;
    logic [SLOT_W-1:0]   result_slot;
    logic [TYPE_W-1:0]   out_type;
    logic [RIGHTS_W-1:0] out_rights;
    logic [WORD_W-1:0]   out_object;
    logic [WORD_W-1:0]   out_badge;
    logic [GEN_W-1:0]    out_generation;
    logic [COUNT_W-1:0]  used_count;

    capability_table_engine u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .slot           (slot),
        .dest_slot      (dest_slot),
        .dst_auto       (dst_auto),
        .cap_type       (cap_type),
        .rights         (rights),
        .object_ref     (object_ref),
        .badge          (badge),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .done           (done),
        .ok             (ok),
        .result_slot    (result_slot),
        .out_type       (out_type),
        .out_rights     (out_rights),
        .out_object     (out_object),
        .out_badge      (out_badge),
        .out_generation (out_generation),
        .used_count     (used_count)
    );

    always #5 clk = ~clk;

    // requests waiting to be driven, and table results owed by the engine
    req_t request_backlog[$];
    res_t owed_results[$];

    int mismatch_count = 0;
    int idle_cycles = 0;

    // shadow copy of the capability space
    logic [TYPE_W-1:0]   tbl_type   [SLOTS] = '{default: '0};
    logic [RIGHTS_W-1:0] tbl_rights [SLOTS] = '{default: '0};
    logic [WORD_W-1:0]   tbl_object [SLOTS] = '{default: '0};
    logic [WORD_W-1:0]   tbl_badge  [SLOTS] = '{default: '0};
    logic [GEN_W-1:0]    tbl_gen    [SLOTS] = '{default: '0};
    logic                tbl_used   [SLOTS] = '{default: 1'b0};
    int                  tbl_count = 0;
    logic [GEN_W-1:0]    space_gen = GEN_RESET;
    logic [BIT_W-1:0]    grant_bit_cfg = GRANT_RESET;
    logic [BIT_W-1:0]    revoke_bit_cfg = REVOKE_RESET;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        // keep the log readable when the engine is badly broken
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t mismatch %s: got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int lowest_free_slot();
        for (int i = 0; i < SLOTS; i++)
            if (!tbl_used[i])
                return i;
        return -1;
    endfunction

    // new entries carry the current space generation and claim their slot
    function automatic void store_entry(input int d, input logic [TYPE_W-1:0] t,
                                        input logic [RIGHTS_W-1:0] r,
                                        input logic [WORD_W-1:0] obj,
                                        input logic [WORD_W-1:0] bdg);
        tbl_type[d]   = t;
        tbl_rights[d] = r;
        tbl_object[d] = obj;
        tbl_badge[d]  = bdg;
        tbl_gen[d]    = space_gen;
        tbl_used[d]   = 1'b1;
        tbl_count++;
    endfunction

    // applies one request to the shadow table and returns what the engine should report
    function automatic res_t table_op_outcome(input req_t r);
        res_t res;
        int src;
        int dst;
        logic src_live;
        res = '0;
        src = int'(r.slot);
        dst = -1;
        src_live = (src < SLOTS) && (tbl_type[src] != TYPE_NONE);
        case (r.func)
            FN_INSERT:
            begin
                // type none never enters the table
                if (r.cap_type != TYPE_NONE)
                    dst = lowest_free_slot();
                if (dst >= 0)
                begin
                    store_entry(dst, r.cap_type, r.rights, r.object_ref, r.badge);
                    res.ok = 1'b1;
                    res.result_slot = SLOT_W'(dst);
                end
            end
            FN_LOOKUP:
            begin
                if (src_live)
                begin
                    res.ok = 1'b1;
                    res.cap_type = tbl_type[src];
                    res.rights = tbl_rights[src];
                    res.object_ref = tbl_object[src];
                    res.badge = tbl_badge[src];
                    res.generation = tbl_gen[src];
                end
            end
            FN_DELETE:
            begin
                if (src_live)
                begin
                    tbl_type[src]   = TYPE_NONE;
                    tbl_rights[src] = '0;
                    tbl_object[src] = '0;
                    tbl_badge[src]  = '0;
                    tbl_gen[src]    = '0;
                    if (tbl_used[src] && tbl_count > 0)
                        tbl_count--;
                    tbl_used[src] = 1'b0;
                    res.ok = 1'b1;
                end
            end
            FN_COPY, FN_MINT:
            begin
                // source must hold the grant right; explicit destination must be empty
                if (src_live && tbl_rights[src][grant_bit_cfg])
                begin
                    if (r.dst_auto)
                        dst = lowest_free_slot();
                    else if (r.dest_slot < SLOTS && tbl_type[r.dest_slot] == TYPE_NONE)
                        dst = int'(r.dest_slot);
                end
                if (dst >= 0)
                begin
                    if (r.func == FN_MINT)
                        store_entry(dst, tbl_type[src], tbl_rights[src] & r.rights,
                                    tbl_object[src], r.badge);
                    else
                        store_entry(dst, tbl_type[src], tbl_rights[src],
                                    tbl_object[src], tbl_badge[src]);
                    res.ok = 1'b1;
                    res.result_slot = SLOT_W'(dst);
                end
            end
            FN_REVOKE:
            begin
                if (src_live && tbl_rights[src][revoke_bit_cfg])
                begin
                    space_gen = space_gen + GEN_W'(1);
                    res.ok = 1'b1;
                end
            end
            default:
            begin
                // unused function codes fail and leave the table alone
            end
        endcase
        res.used_count = COUNT_W'(tbl_count);
        return res;
    endfunction

    function automatic req_t make_req(input logic [FUNC_W-1:0] f, input int s, input int d,
                                      input logic a, input logic [TYPE_W-1:0] t,
                                      input logic [RIGHTS_W-1:0] r,
                                      input logic [WORD_W-1:0] obj,
                                      input logic [WORD_W-1:0] bdg);
        req_t q;
        q.func = f;
        q.slot = SLOT_IN_W'(s);
        q.dest_slot = SLOT_IN_W'(d);
        q.dst_auto = a;
        q.cap_type = t;
        q.rights = r;
        q.object_ref = obj;
        q.badge = bdg;
        return q;
    endfunction

    function automatic logic [SLOT_IN_W-1:0] random_slot_index();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return SLOT_IN_W'($urandom_range(SLOTS, 255));
        else if (pick < 9)
            return SLOT_IN_W'($urandom_range(0, 7));
        return SLOT_IN_W'($urandom_range(0, SLOTS - 1));
    endfunction

    // mostly legal requests on a dense low region of the table, with some noise
    function automatic req_t random_request(input int insert_pct, input logic [BIT_W-1:0] g,
                                            input logic [BIT_W-1:0] v);
        req_t q;
        int pick;
        q.slot = random_slot_index();
        q.dest_slot = random_slot_index();
        q.dst_auto = 1'($urandom_range(0, 1));
        q.cap_type = TYPE_W'($urandom_range(0, 7));
        q.rights = RIGHTS_W'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1)
            q.rights = q.rights | (RIGHTS_W'(1) << g) | (RIGHTS_W'(1) << v);
        q.object_ref = {$urandom, $urandom};
        q.badge = {$urandom, $urandom};
        if ($urandom_range(0, 99) < insert_pct)
            q.func = FN_INSERT;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                q.func = (pick == 0) ? FN_UNUSED_7 : FN_UNUSED_6;
            else if (pick < 33)
                q.func = FN_LOOKUP;
            else if (pick < 55)
                q.func = FN_DELETE;
            else if (pick < 72)
                q.func = FN_COPY;
            else if (pick < 89)
                q.func = FN_MINT;
            else
                q.func = FN_REVOKE;
        end
        return q;
    endfunction

    // request driver: holds start until the engine takes the request, then idles a while
    int hold_off = 0;
    int calm_run = 0;

    always @(posedge clk)
    begin
        req_t nxt;
        int gap;
        if (!rst_n)
        begin
            start <= 1'b0;
            hold_off <= 0;
        end
        else if (!(start && busy))
        begin
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                start <= 1'b0;
            end
            else if (request_backlog.size() > 0)
            begin
                nxt = request_backlog.pop_front();
                func       <= nxt.func;
                slot       <= nxt.slot;
                dest_slot  <= nxt.dest_slot;
                dst_auto   <= nxt.dst_auto;
                cap_type   <= nxt.cap_type;
                rights     <= nxt.rights;
                object_ref <= nxt.object_ref;
                badge      <= nxt.badge;
                start      <= 1'b1;
                // now and then a run of back-to-back requests
                if (calm_run > 0)
                begin
                    gap = 0;
                    calm_run--;
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    gap = 0;
                    calm_run = $urandom_range(10, 40);
                end
                else
                    gap = $urandom_range(0, 10);
                hold_off <= gap;
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: checks results against the shadow table, then predicts newly taken requests
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        req_t taken;
        if (rst_n)
        begin
            if (done)
            begin
                got = {ok, result_slot, out_type, out_rights, out_object, out_badge,
                       out_generation, used_count};
                if (owed_results.size() == 0)
                    report_mismatch("result with no request outstanding", got.object_ref, '0);
                else
                begin
                    want = owed_results.pop_front();
                    if (got.ok !== want.ok)
                        report_mismatch("ok", WORD_W'(got.ok), WORD_W'(want.ok));
                    if (got.result_slot !== want.result_slot)
                        report_mismatch("result_slot", WORD_W'(got.result_slot),
                                        WORD_W'(want.result_slot));
                    if (got.cap_type !== want.cap_type)
                        report_mismatch("out_type", WORD_W'(got.cap_type),
                                        WORD_W'(want.cap_type));
                    if (got.rights !== want.rights)
                        report_mismatch("out_rights", WORD_W'(got.rights),
                                        WORD_W'(want.rights));
                    if (got.object_ref !== want.object_ref)
                        report_mismatch("out_object", got.object_ref, want.object_ref);
                    if (got.badge !== want.badge)
                        report_mismatch("out_badge", got.badge, want.badge);
                    if (got.generation !== want.generation)
                        report_mismatch("out_generation", WORD_W'(got.generation),
                                        WORD_W'(want.generation));
                    if (got.used_count !== want.used_count)
                        report_mismatch("used_count", WORD_W'(got.used_count),
                                        WORD_W'(want.used_count));
                end
            end
            if (start && !busy)
            begin
                taken = {func, slot, dest_slot, dst_auto, cap_type, rights, object_ref, badge};
                owed_results.push_back(table_op_outcome(taken));
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GRANT_BIT:  grant_bit_cfg = cfg_data;
                    CFG_REVOKE_BIT: revoke_bit_cfg = cfg_data;
                    default:        ;
                endcase
            end
        end
    end

    // watchdog on cycles where neither a request nor a result moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // wait until every queued request went in and every result came back
    task automatic drain_requests();
        while (request_backlog.size() != 0 || start || owed_results.size() != 0)
            @(posedge clk);
        // the result strobe trails acceptance through the engine's request and result registers
        repeat (4) @(posedge clk);
    endtask

    task automatic write_rights_cfg(input logic [BIT_W-1:0] g, input logic [BIT_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_GRANT_BIT;
        cfg_data <= g;
        @(posedge clk);
        cfg_index <= CFG_REVOKE_BIT;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [WORD_W-1:0] ones;
        logic [WORD_W-1:0] pattern;
        logic [BIT_W-1:0] g;
        logic [BIT_W-1:0] v;
        int ins_pct;
        ones = '1;
        pattern = 64'hA5C3_0F1E_9B72_4D68;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pass at the reset rights layout: grant bit 2, revoke bit 3
        request_backlog.push_back(make_req(FN_LOOKUP, 0, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_DELETE, 0, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        // insert of type none is refused
        request_backlog.push_back(make_req(FN_INSERT, 0, 0, 1'b0, TYPE_NONE, 8'hFF, ones, ones));
        request_backlog.push_back(make_req(FN_INSERT, 0, 0, 1'b0, 3'd7, 8'hFF, ones, ones));
        request_backlog.push_back(make_req(FN_INSERT, 255, 255, 1'b1, 3'd1, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_LOOKUP, 0, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_LOOKUP, 255, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_COPY, 0, 0, 1'b1, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_MINT, 0, 63, 1'b0, 3'd0, 8'h0F, '0, pattern));
        request_backlog.push_back(make_req(FN_LOOKUP, 63, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        // occupied and out-of-range explicit destinations
        request_backlog.push_back(make_req(FN_COPY, 0, 1, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_COPY, 0, 200, 1'b0, 3'd0, 8'h00, '0, '0));
        // slot 1 holds no rights at all
        request_backlog.push_back(make_req(FN_COPY, 1, 0, 1'b1, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_MINT, 64, 0, 1'b1, 3'd0, 8'hFF, '0, '0));
        request_backlog.push_back(make_req(FN_REVOKE, 1, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_REVOKE, 0, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_INSERT, 0, 0, 1'b0, 3'd3, 8'h55, pattern, ~pattern));
        request_backlog.push_back(make_req(FN_LOOKUP, 3, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_UNUSED_6, 0, 0, 1'b0, 3'd1, 8'hFF, '0, '0));
        request_backlog.push_back(make_req(FN_UNUSED_7, 0, 0, 1'b0, 3'd1, 8'hFF, '0, '0));
        request_backlog.push_back(make_req(FN_DELETE, 63, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_LOOKUP, 63, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_DELETE, 255, 0, 1'b0, 3'd0, 8'h00, '0, '0));

        // fill the table, then hit it while full
        for (int i = 0; i < 62; i++)
            request_backlog.push_back(make_req(FN_INSERT, 0, 0, 1'b0, TYPE_W'($urandom_range(1, 7)),
                                               8'hFF, {$urandom, $urandom}, {$urandom, $urandom}));
        request_backlog.push_back(make_req(FN_INSERT, 0, 0, 1'b0, 3'd2, 8'hFF, ones, ones));
        request_backlog.push_back(make_req(FN_COPY, 0, 0, 1'b1, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_MINT, 0, 10, 1'b0, 3'd0, 8'hFF, '0, ones));
        request_backlog.push_back(make_req(FN_DELETE, 5, 0, 1'b0, 3'd0, 8'h00, '0, '0));
        request_backlog.push_back(make_req(FN_MINT, 0, 0, 1'b1, 3'd0, 8'hF0, '0, pattern));
        drain_requests();

        // random phases, each under its own rights layout, extremes included
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:       begin g = 3'd0; v = 3'd7; ins_pct = 45; end
                1:       begin g = 3'd7; v = 3'd0; ins_pct = 25; end
                2:       begin g = 3'd7; v = 3'd7; ins_pct = 40; end
                3:       begin g = 3'd0; v = 3'd0; ins_pct = 20; end
                4:       begin g = BIT_W'($urandom_range(0, 7)); v = BIT_W'($urandom_range(0, 7));
                               ins_pct = 35; end
                default: begin g = GRANT_RESET; v = REVOKE_RESET; ins_pct = 30; end
            endcase
            write_rights_cfg(g, v);
            for (int i = 0; i < PHASE_ITEMS; i++)
                request_backlog.push_back(random_request(ins_pct, g, v));
            drain_requests();
        end

        if (owed_results.size() != 0)
            report_mismatch("results never delivered", WORD_W'(owed_results.size()), '0);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
